@@ design/heading_error_motor_drive_assert.svh @@
// ----------------------------------------------------------------------------
// heading error motor drive assertion macros
// Concurrent assertion wrappers for the heading error motor drive block.
// ----------------------------------------------------------------------------
`ifndef HEADING_ERROR_MOTOR_DRIVE_ASSERT_SVH
`define HEADING_ERROR_MOTOR_DRIVE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked at every clk edge outside reset
`define HED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define HED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HED_ASSERT_IMP(lbl, ante, cons, msg)
`define HED_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/hed_pkg.sv @@
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, constants and tables of the heading error motor drive.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;

  // cordic datapath: 17-bit vector scaled by 2^30, plus gain and sign headroom
  localparam int PRESCALE_SH = 30;
  localparam int CW          = 50;

  // product of wrapped error and half span
  localparam int PW = ANGLE_BITS + 11;

  localparam int LATENCY = CORDIC_STEPS + 6;

  localparam int PADDR_W = 5;

  localparam logic [31:0] HALF_TURN32 = 32'h8000_0000;
  localparam logic [31:0] ROUND32     = 32'(1) << (32 - ANGLE_BITS - 1);
  localparam logic [PW-1:0] TRUNC_BIAS = PW'((1 << (ANGLE_BITS - 1)) - 1);

  localparam logic [11:0] DUTY_CENTER_RST = 12'd750;
  localparam logic [9:0]  DUTY_SPAN_RST   = 10'd150;
  localparam logic [11:0] DUTY_MAX        = 12'd4095;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN32 [0:ATAN_LEN-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef logic [ANGLE_BITS-1:0] angle_t;

  typedef enum logic [2:0] {
    REG_OFFSET_X   = 3'd0,
    REG_OFFSET_Y   = 3'd1,
    REG_SCALE_NEG  = 3'd2,
    REG_DUTY_CTR   = 3'd3,
    REG_DUTY_SPAN  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic        [15:0] encoder_angle;
  } in_beat_t;

  typedef struct packed {
    logic        [15:0] heading;
    logic signed [15:0] angle_error;
    logic        [11:0] duty_command;
  } out_beat_t;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    angle_t             enc;
  } cordic_req_t;

  typedef struct packed {
    logic [31:0] z;
    angle_t      enc;
  } cordic_rsp_t;

endpackage

@@ design/hed_cordic.sv @@
// ----------------------------------------------------------------------------
// hed_cordic
// Pipelined vectoring cordic: atan2(y, x) as a 32-bit binary angle, one stage
// per micro-rotation, one vector accepted every cycle.
// ----------------------------------------------------------------------------
module hed_cordic
  import hed_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  input  cordic_req_t req,
  output logic        rsp_valid,
  output cordic_rsp_t rsp
);

  // index 0 is the half-plane pre-rotation, index i+1 follows micro-rotation i
  logic                  v_r    [0:CORDIC_STEPS];
  logic signed [CW-1:0]  sx_r   [0:CORDIC_STEPS];
  logic signed [CW-1:0]  sy_r   [0:CORDIC_STEPS];
  logic        [31:0]    sz_r   [0:CORDIC_STEPS];
  logic                  zero_r [0:CORDIC_STEPS];
  angle_t                enc_r  [0:CORDIC_STEPS];

  logic signed [CW-1:0] px_nxt, py_nxt, xw, yw;
  logic        [31:0]   pz_nxt;

  // fold the left half plane over by a half turn
  always_comb begin
    xw = CW'(req.x) <<< PRESCALE_SH;
    yw = CW'(req.y) <<< PRESCALE_SH;
    if (req.x < 0) begin
      px_nxt = -xw;
      py_nxt = -yw;
      pz_nxt = HALF_TURN32;
    end else begin
      px_nxt = xw;
      py_nxt = yw;
      pz_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    sx_r[0]   <= px_nxt;
    sy_r[0]   <= py_nxt;
    sz_r[0]   <= pz_nxt;
    zero_r[0] <= (req.x == '0) && (req.y == '0);
    enc_r[0]  <= req.enc;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CW-1:0] xs, ys, x_nxt, y_nxt;
    logic        [31:0]   z_nxt;

    always_comb begin
      xs = sx_r[i] >>> i;
      ys = sy_r[i] >>> i;
      if (sy_r[i] > 0) begin
        x_nxt = sx_r[i] + ys;
        y_nxt = sy_r[i] - xs;
        z_nxt = sz_r[i] + ATAN_TURN32[i];
      end else begin
        x_nxt = sx_r[i] - ys;
        y_nxt = sy_r[i] + xs;
        z_nxt = sz_r[i] - ATAN_TURN32[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      sx_r[i+1]   <= x_nxt;
      sy_r[i+1]   <= y_nxt;
      sz_r[i+1]   <= z_nxt;
      zero_r[i+1] <= zero_r[i];
      enc_r[i+1]  <= enc_r[i];
    end
  end

  assign rsp_valid = v_r[CORDIC_STEPS];
  // null vector has heading zero
  assign rsp.z     = zero_r[CORDIC_STEPS] ? '0 : sz_r[CORDIC_STEPS];
  assign rsp.enc   = enc_r[CORDIC_STEPS];

endmodule

@@ design/heading_error_motor_drive.sv @@
// ----------------------------------------------------------------------------
// heading_error_motor_drive
// Magnetic heading by pipelined cordic atan2, wrapped error against the
// encoder angle, and a proportional, saturated motor duty.
//
//   channel  | ports                                  | beat
//   ---------+----------------------------------------+----------------------
//   input    | start, busy, in_data                   | start && !busy
//   result   | out_strobe, out_data                   | out_strobe, one cycle
//   config   | psel, penable, pwrite, paddr, pwdata,  | psel && penable &&
//            | prdata, pready                         | pwrite (pready high)
//
// One beat per cycle in, one result per beat out, registered through stage 0, the
// cordic pre-rotation and one cordic stage per step, stages a to c and the output.
// busy is high only during reset and the cycle after; the pipeline never stalls.
// Reset is synchronous, active low, and resets the valid bits and configuration registers.
// ----------------------------------------------------------------------------
`include "heading_error_motor_drive_assert.svh"

module heading_error_motor_drive
  import hed_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_beat_t           in_data,
  output logic               out_strobe,
  output out_beat_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic signed [15:0] offset_x_r, offset_y_r;
  logic               scale_neg_r;
  logic        [11:0] duty_center_r;
  logic        [9:0]  duty_span_r;

  logic     busy_r;
  logic     accept, cfg_wr;
  cfg_idx_t cfg_idx;

  assign accept  = start && !busy_r;
  assign busy    = busy_r;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r    <= '0;
      offset_y_r    <= '0;
      scale_neg_r   <= 1'b0;
      duty_center_r <= DUTY_CENTER_RST;
      duty_span_r   <= DUTY_SPAN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OFFSET_X:  offset_x_r    <= pwdata[15:0];
        REG_OFFSET_Y:  offset_y_r    <= pwdata[15:0];
        REG_SCALE_NEG: scale_neg_r   <= pwdata[0];
        REG_DUTY_CTR:  duty_center_r <= pwdata[11:0];
        REG_DUTY_SPAN: duty_span_r   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_OFFSET_X:  prdata = 32'(offset_x_r);
      REG_OFFSET_Y:  prdata = 32'(offset_y_r);
      REG_SCALE_NEG: prdata = 32'(scale_neg_r);
      REG_DUTY_CTR:  prdata = 32'(duty_center_r);
      REG_DUTY_SPAN: prdata = 32'(duty_span_r);
      default:       prdata = '0;
    endcase
  end

  // stage 0: hard-iron correction, y negated for atan2(-y, x)
  logic        v0_r;
  cordic_req_t req_r;
  cordic_req_t req_nxt;

  always_comb begin
    req_nxt.x   = 17'(in_data.mag_x) - 17'(offset_x_r);
    req_nxt.y   = 17'(offset_y_r) - 17'(in_data.mag_y);
    req_nxt.enc = angle_t'(in_data.encoder_angle);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  logic        rsp_valid;
  cordic_rsp_t rsp;

  hed_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (v0_r),
    .req       (req_r),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // stage a: round to the angle width, half turn for a negative scale
  logic        va_r;
  angle_t      head_a_r, enc_a_r, head_a_nxt;
  logic [31:0] rnd_sum;

  always_comb begin
    rnd_sum    = rsp.z + ROUND32;
    head_a_nxt = rnd_sum[31 -: ANGLE_BITS];
    head_a_nxt[ANGLE_BITS-1] = head_a_nxt[ANGLE_BITS-1] ^ scale_neg_r;
  end

  // stage b: wrapped error
  logic                         vb_r;
  angle_t                       head_b_r;
  logic signed [ANGLE_BITS-1:0] err_b_r;

  // stage c: error times half span
  logic                         vc_r;
  angle_t                       head_c_r;
  logic signed [ANGLE_BITS-1:0] err_c_r;
  logic signed [PW-1:0]         prod_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= rsp_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    head_a_r <= head_a_nxt;
    enc_a_r  <= rsp.enc;
    head_b_r <= head_a_r;
    err_b_r  <= head_a_r - enc_a_r;
    head_c_r <= head_b_r;
    err_c_r  <= err_b_r;
    prod_c_r <= PW'(err_b_r) * PW'($signed({1'b0, duty_span_r}));
  end

  // stage d: divide by a half turn toward zero, add center, saturate
  logic signed [PW-1:0] prod_biased, q_full;
  logic signed [11:0]   q;
  logic signed [13:0]   duty_sum;
  logic        [11:0]   duty_sat;

  always_comb begin
    prod_biased = prod_c_r + (prod_c_r[PW-1] ? TRUNC_BIAS : '0);
    q_full      = prod_biased >>> (ANGLE_BITS - 1);
    q           = q_full[11:0];
    duty_sum    = $signed({2'b00, duty_center_r}) + 14'(q);
    if (duty_sum < 0) begin
      duty_sat = '0;
    end else if (duty_sum > $signed({2'b00, DUTY_MAX})) begin
      duty_sat = DUTY_MAX;
    end else begin
      duty_sat = duty_sum[11:0];
    end
  end

  logic      out_strobe_r;
  out_beat_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.heading      <= 16'(head_c_r);
    out_data_r.angle_error  <= 16'(err_c_r);
    out_data_r.duty_command <= duty_sat;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // every result traces back to a beat taken at the input
  `HED_ASSERT_IMP(a_result_origin, out_strobe, $past(start && !busy, LATENCY), "result without beat")
  // a non-negative error never pulls the duty below center
  `HED_ASSERT_IMP(a_duty_side, out_strobe && !out_data.angle_error[15], out_data.duty_command >= duty_center_r, "duty on wrong side")
  // out of reset the block takes beats from the next cycle on
  `HED_ASSERT_NXT(a_ready_after_reset, 1'b1, !busy, "busy after reset")

endmodule

@@ tb/heading_error_motor_drive_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_error_motor_drive_test
// Drives magnetometer/encoder samples into the heading drive across several
// register settings and checks every heading, wrapped error and motor duty
// against a cycle-free model of the cordic heading and proportional drive.
// ----------------------------------------------------------------------------
module heading_error_motor_drive_test;
  import hed_pkg::*;

  localparam int PIPE_DEPTH  = 22;
  localparam int STALL_LIMIT = 2000;
  localparam int ROT_STEPS   = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_beat_t in_data = '0;
  logic out_strobe;
  out_beat_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // register copies seen by the drive model
  logic signed [15:0] hard_iron_x = '0;
  logic signed [15:0] hard_iron_y = '0;
  logic flip_half_turn = 1'b0;
  logic [11:0] center_duty = 12'd750;
  logic [9:0] span_duty = 10'd150;

  in_beat_t sample_q[$];
  out_beat_t drive_q[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  logic took_beat = 1'b0;
  logic steady = 1'b0;

  heading_error_motor_drive dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // atan(2^-i) on a 2^32 turn
  function automatic logic [31:0] atan_turn(int i);
    case (i)
      0: return 32'h20000000;  1: return 32'h12E4051E;
      2: return 32'h09FB385B;  3: return 32'h051111D4;
      4: return 32'h028B0D43;  5: return 32'h0145D7E1;
      6: return 32'h00A2F61E;  7: return 32'h00517C55;
      8: return 32'h0028BE53;  9: return 32'h00145F2F;
      10: return 32'h000A2F98; 11: return 32'h000517CC;
      12: return 32'h00028BE6; 13: return 32'h000145F3;
      14: return 32'h0000A2FA; default: return 32'h0000517D;
    endcase
  endfunction

  function automatic out_beat_t drive_from_sample(in_beat_t s);
    longint dx, dy, x, y, xs, ys, prod, q, duty;
    logic [31:0] z, rounded;
    logic [15:0] hd, diff;
    logic signed [15:0] err;
    out_beat_t r;
    dx = $signed(s.mag_x) - $signed(hard_iron_x);
    dy = $signed(s.mag_y) - $signed(hard_iron_y);
    z = '0;
    // heading is atan2(-y, x); a zero vector points at angle zero
    if (dx != 0 || dy != 0) begin
      x = dx <<< 30;
      y = (-dy) <<< 30;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_turn(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_turn(i);
        end
      end
    end
    rounded = z + 32'h0000_8000;
    hd = rounded[31:16];
    if (flip_half_turn) hd = hd + 16'h8000;
    diff = hd - s.encoder_angle;
    err = diff;
    prod = err * $signed({1'b0, span_duty});
    q = (prod >= 0) ? (prod >>> 15) : -((-prod) >>> 15);
    duty = q + $signed({1'b0, center_duty});
    if (duty < 0) duty = 0;
    if (duty > 4095) duty = 4095;
    r.heading = hd;
    r.angle_error = err;
    r.duty_command = duty[11:0];
    return r;
  endfunction

  // driver: hold a beat until taken, idle at random otherwise
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_beat) begin
      if (sample_q.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
        start <= 1'b1;
        in_data <= sample_q.pop_front();
      end else begin
        start <= 1'b0;
        in_data <= in_beat_t'({$urandom, $urandom});
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_beat_t want;
    took_beat <= rst_n && start && !busy;
    if (rst_n && out_strobe) begin
      if (drive_q.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = drive_q.pop_front();
        if (out_data.heading !== want.heading) begin
          $display("%0t: heading expected %h got %h", $time, want.heading,
                   out_data.heading);
          mismatches++;
        end
        if (out_data.angle_error !== want.angle_error) begin
          $display("%0t: angle_error expected %h got %h", $time, want.angle_error,
                   out_data.angle_error);
          mismatches++;
        end
        if (out_data.duty_command !== want.duty_command) begin
          $display("%0t: duty_command expected %h got %h", $time, want.duty_command,
                   out_data.duty_command);
          mismatches++;
        end
      end
    end
    if (rst_n && start && !busy) drive_q.push_back(drive_from_sample(in_data));
    if ((rst_n && start && !busy) || out_strobe || (psel && penable && pwrite))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("heading_error_motor_drive test failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_OFFSET_X: hard_iron_x = value[15:0];
      REG_OFFSET_Y: hard_iron_y = value[15:0];
      REG_SCALE_NEG: flip_half_turn = value[0];
      REG_DUTY_CTR: center_duty = value[11:0];
      REG_DUTY_SPAN: span_duty = value[9:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_drive(input logic [15:0] ox, input logic [15:0] oy, input logic neg,
                           input logic [11:0] ctr, input logic [9:0] span);
    write_reg(REG_OFFSET_X, {{16{ox[15]}}, ox});
    write_reg(REG_OFFSET_Y, {{16{oy[15]}}, oy});
    write_reg(REG_SCALE_NEG, {31'd0, neg});
    write_reg(REG_DUTY_CTR, {20'd0, ctr});
    write_reg(REG_DUTY_SPAN, {22'd0, span});
    @(posedge clk);
  endtask

  task automatic add_sample(input logic [15:0] mx, input logic [15:0] my,
                            input logic [15:0] enc);
    in_beat_t s;
    s.mag_x = mx;
    s.mag_y = my;
    s.encoder_angle = enc;
    sample_q.push_back(s);
  endtask

  task automatic add_random(input int n);
    in_beat_t s;
    out_beat_t p;
    int kind;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 9);
      s = in_beat_t'({$urandom, $urandom});
      if (kind == 4 || kind == 5) begin
        // tiny vectors around the offset point
        s.mag_x = hard_iron_x + 16'($urandom_range(0, 16)) - 16'd8;
        s.mag_y = hard_iron_y + 16'($urandom_range(0, 16)) - 16'd8;
      end else if (kind == 6) begin
        if ($urandom_range(0, 1)) s.mag_x = hard_iron_x;
        else s.mag_y = hard_iron_y;
      end else if (kind >= 7) begin
        // encoder near the opposite heading: error close to a half turn
        p = drive_from_sample(s);
        s.encoder_angle = p.heading + 16'h8000 + 16'($urandom_range(0, 600)) - 16'd300;
      end
      sample_q.push_back(s);
    end
  endtask

  task automatic add_corners();
    add_sample(hard_iron_x, hard_iron_y, 16'($urandom));
    add_sample(hard_iron_x, hard_iron_y, 16'h8000);
    add_sample(16'h8000, 16'h8000, 16'($urandom));
    add_sample(16'h7FFF, 16'h7FFF, 16'($urandom));
    add_sample(16'h7FFF, 16'h8000, 16'($urandom));
    add_sample(16'h8000, 16'h7FFF, 16'($urandom));
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || start) @(posedge clk);
    while (drive_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values, directed corners
    add_sample(16'h7FFF, 16'h0000, 16'h0000);
    add_sample(16'h8000, 16'h0000, 16'h0000);
    add_sample(16'h0000, 16'h7FFF, 16'h4000);
    add_sample(16'h0000, 16'h8000, 16'hC000);
    add_sample(16'h7FFF, 16'h7FFF, 16'hFFFF);
    add_sample(16'h8000, 16'h8000, 16'h8000);
    add_sample(16'h8000, 16'h7FFF, 16'h0001);
    add_sample(16'h7FFF, 16'h8000, 16'h7FFF);
    add_sample(16'h0000, 16'h0000, 16'h0000);
    add_sample(16'h0000, 16'h0000, 16'h8000);
    add_sample(16'h0001, 16'h0000, 16'h8000);
    add_sample(16'h0001, 16'h0000, 16'h8001);
    add_sample(16'hFFFF, 16'h0000, 16'h0000);
    add_sample(16'h0000, 16'hFFFF, 16'h0000);
    add_sample(16'h0000, 16'h0001, 16'h0000);
    add_sample(16'h0003, 16'hFFFC, 16'hAAAA);
    add_sample(16'hFFFB, 16'h0005, 16'h5555);
    add_random(300);
    drain();

    set_drive(16'h8000, 16'h7FFF, 1'b1, 12'd4095, 10'd1023);
    add_corners();
    add_random(215);
    drain();

    set_drive(16'h7FFF, 16'h8000, 1'b0, 12'd0, 10'd1023);
    add_corners();
    add_random(215);
    drain();

    set_drive(16'($urandom_range(0, 400)) - 16'd200, 16'($urandom_range(0, 400)) - 16'd200,
              1'b1, 12'd2048, 10'd0);
    add_corners();
    add_random(215);
    drain();

    // back-to-back beats with no gaps
    steady = 1'b1;
    set_drive(16'($urandom), 16'($urandom), 1'($urandom), 12'($urandom), 10'($urandom));
    add_corners();
    add_random(215);
    drain();
    steady = 1'b0;

    set_drive(16'($urandom), 16'($urandom), 1'($urandom), 12'($urandom), 10'($urandom));
    add_corners();
    add_random(215);
    drain();

    set_drive(16'h0000, 16'h0000, 1'b0, 12'd750, 10'd150);
    add_corners();
    add_random(215);
    drain();

    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("heading_error_motor_drive test passed");
    end else begin
      $display("heading_error_motor_drive test failed");
    end
    $finish;
  end

endmodule
